### hdl/sqrot_pkg.sv
// sqrot_pkg: shared types and command codes for the square image quarter-turn rotator
// depends on nothing; used by sqrot_ctrl, sqrot_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package sqrot_pkg;

   // widths of the word fields
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned COORD_W = 6;
   localparam int unsigned PIX_W   = 24;
   localparam int unsigned CSR_W   = 7;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RIGHT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   // request word
   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
      logic [PIX_W-1:0]   pixel_in;
   } req_type;

   // response word
   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             out_of_range;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic turn_left;
      logic turn_right;
      logic clear_turns;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_range;
   } ctl_status_type;

endpackage

`default_nettype wire

### hdl/sqrot_dp.sv
// sqrot_dp: image store, size and turn registers, read address mapping
// depends on sqrot_pkg; driven by commands from sqrot_ctrl
`timescale 1ns / 1ps
`default_nettype none

module sqrot_dp #(
   parameter int unsigned MAX_SIZE    = 64,
   parameter int unsigned PIXEL_WIDTH = 24
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_wr_en,
   input  wire  [sqrot_pkg::CSR_W-1:0]            csr_wr_data,
   input  wire  sqrot_pkg::req_type               req_word,
   input  wire  sqrot_pkg::ctl_cmd_type           cmd,
   output sqrot_pkg::ctl_status_type              status,
   output sqrot_pkg::rsp_type                     rsp_word
);

   localparam int unsigned SIZE_CLOG = $clog2(MAX_SIZE + 1);
   localparam int unsigned SIZE_W    = (SIZE_CLOG > sqrot_pkg::CSR_W) ?
                                       SIZE_CLOG : sqrot_pkg::CSR_W;
   localparam int unsigned IDX_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int unsigned PROD_W    = 2 * IDX_W;
   localparam int unsigned DEPTH     = MAX_SIZE * MAX_SIZE;
   localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned STORE_W   = (PIXEL_WIDTH < sqrot_pkg::PIX_W) ?
                                       PIXEL_WIDTH : sqrot_pkg::PIX_W;

   localparam logic [1:0] TURN_NONE = 2'd0;
   localparam logic [1:0] TURN_ONE  = 2'd1;
   localparam logic [1:0] TURN_TWO  = 2'd2;
   localparam logic [1:0] TURN_SAT  = 2'd3;

   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [1:0]         turns_ff, turns_in;
   logic [STORE_W-1:0] rd_data_ff;
   logic               oor_ff;
   logic [STORE_W-1:0] image_mem [DEPTH];

   logic [SIZE_W-1:0]  row_ext, col_ext, size_req, nm1;
   logic [SIZE_W-1:0]  map_row, map_col;
   logic [PROD_W-1:0]  wr_prod, rd_prod;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;

   // size register, saturated to the store size on write
   always_comb begin
      size_req = SIZE_W'(csr_wr_data);
      if (size_req > SIZE_W'(MAX_SIZE)) begin
         size_in = SIZE_W'(MAX_SIZE);
      end else begin
         size_in = size_req;
      end
   end

   // range check against the size in effect
   always_comb begin
      row_ext         = SIZE_W'(req_word.row);
      col_ext         = SIZE_W'(req_word.column);
      nm1             = size_ff - SIZE_W'(1);
      status.in_range = (row_ext < size_ff) && (col_ext < size_ff);
   end

   // map view position onto stored position
   always_comb begin
      case (turns_ff)
         TURN_ONE: begin
            map_row = col_ext;
            map_col = nm1 - row_ext;
         end
         TURN_TWO: begin
            map_row = nm1 - row_ext;
            map_col = nm1 - col_ext;
         end
         TURN_SAT: begin
            map_row = nm1 - col_ext;
            map_col = row_ext;
         end
         default: begin
            map_row = row_ext;
            map_col = col_ext;
         end
      endcase
   end

   // linear addresses, row major
   always_comb begin
      wr_prod = PROD_W'(row_ext[IDX_W-1:0]) * PROD_W'(MAX_SIZE)
              + PROD_W'(col_ext[IDX_W-1:0]);
      rd_prod = PROD_W'(map_row[IDX_W-1:0]) * PROD_W'(MAX_SIZE)
              + PROD_W'(map_col[IDX_W-1:0]);
      wr_addr = wr_prod[ADDR_W-1:0];
      rd_addr = rd_prod[ADDR_W-1:0];
   end

   // net quarter-turn count, modulo four
   always_comb begin
      turns_in = turns_ff;
      if (cmd.clear_turns) begin
         turns_in = TURN_NONE;
      end else if (cmd.turn_left) begin
         turns_in = turns_ff + 2'd1;
      end else if (cmd.turn_right) begin
         turns_in = turns_ff - 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= '0;
         turns_ff <= TURN_NONE;
      end else begin
         if (csr_wr_en) begin
            size_ff <= size_in;
         end
         turns_ff <= turns_in;
      end
   end

   // image store, one access per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         image_mem[wr_addr] <= req_word.pixel_in[STORE_W-1:0];
      end
      if (cmd.rd_en) begin
         rd_data_ff <= image_mem[rd_addr];
         oor_ff     <= !status.in_range;
      end
   end

   // response word
   always_comb begin
      rsp_word.out_of_range = oor_ff;
      rsp_word.pixel_out    = oor_ff ? '0 : sqrot_pkg::PIX_W'(rd_data_ff);
   end

   // a load always leaves the turn count at zero
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_turns |=> (turns_ff == TURN_NONE))
      else $error("turn count not cleared after load");

   // a left turn steps the count up by one
   a_left_steps: assert property (@(posedge clock) disable iff (reset)
      (cmd.turn_left && !cmd.clear_turns) |=> (turns_ff == $past(turns_ff) + 2'd1))
      else $error("left turn did not advance count");

   // a right turn steps the count down by one
   a_right_steps: assert property (@(posedge clock) disable iff (reset)
      (cmd.turn_right && !cmd.clear_turns && !cmd.turn_left)
      |=> (turns_ff == $past(turns_ff) - 2'd1))
      else $error("right turn did not step count back");

endmodule

`default_nettype wire

### hdl/sqrot_ctrl.sv
// sqrot_ctrl: command decode and response sequencing for the rotator
// depends on sqrot_pkg; drives sqrot_dp through command and status structs
`timescale 1ns / 1ps
`default_nettype none

module sqrot_ctrl (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire  [sqrot_pkg::CMD_W-1:0]         command,
   input  wire  sqrot_pkg::ctl_status_type     status,
   output sqrot_pkg::ctl_cmd_type              cmd,
   output logic                                busy,
   output logic                                rsp_valid
);

   typedef enum logic {
      ST_IDLE,
      ST_REPLY
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   // decode an accepted word into datapath commands
   always_comb begin
      cmd      = '0;
      state_in = ST_IDLE;
      if (accept) begin
         unique case (command)
            sqrot_pkg::CMD_LOAD: begin
               cmd.wr_en       = status.in_range;
               cmd.clear_turns = 1'b1;
            end
            sqrot_pkg::CMD_LEFT: begin
               cmd.turn_left = 1'b1;
            end
            sqrot_pkg::CMD_RIGHT: begin
               cmd.turn_right = 1'b1;
            end
            sqrot_pkg::CMD_READ: begin
               cmd.rd_en = 1'b1;
               state_in  = ST_REPLY;
            end
            default: begin
               cmd = '0;
            end
         endcase
      end
   end

   // state and registered outputs; busy only in the cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = (state_ff == ST_REPLY);

   // a response strobe follows exactly one accepted read
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && (command == sqrot_pkg::CMD_READ)))
      else $error("response without an accepted read");

   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (command == sqrot_pkg::CMD_READ)) |=> rsp_valid)
      else $error("accepted read gave no response");

   // at most one datapath action per cycle
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_en || cmd.clear_turns, cmd.rd_en, cmd.turn_left, cmd.turn_right}))
      else $error("conflicting datapath commands");

   // write only with a load in range
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (status.in_range && cmd.clear_turns))
      else $error("store write outside a valid load");

endmodule

`default_nettype wire

### hdl/square_image_quarter_turn_rotator.sv
// square_image_quarter_turn_rotator: top level joining controller and datapath
// depends on sqrot_pkg, sqrot_ctrl and sqrot_dp
`timescale 1ns / 1ps
`default_nettype none

// Square image store with a net quarter-turn count applied on read.
// Request channel: a word on req_word is taken at a clock edge with start high
// and busy low. Commands are load pixel, turn left, turn right and read pixel.
// A load writes one pixel (if inside the image) and clears the turn count;
// the turns step the count modulo four; a read maps the view position onto
// the stored position and looks it up.
// Response channel: a read answers in the cycle after it is taken, with
// rsp_valid high for exactly one cycle and the word on rsp_word; the receiver
// cannot hold it off. Other commands give no response.
// Throughput is one word per clock while busy is low: each word is one access
// to the single port image memory, whose read data is registered. Back-to-back
// loads, turns and reads see each other in order.
// csr_wr_en/csr_wr_data set the image size, saturated to MAX_SIZE; write it
// only while no read is outstanding.
// Reset clears the size and turn count; busy is high for the cycle after
// reset and low from then on. Pixels are undefined until loaded.
module square_image_quarter_turn_rotator #(
   parameter int unsigned MAX_SIZE    = 64,
   parameter int unsigned PIXEL_WIDTH = 24
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   output logic                            busy,
   input  wire  sqrot_pkg::req_type        req_word,
   output logic                            rsp_valid,
   output sqrot_pkg::rsp_type              rsp_word,
   input  wire                             csr_wr_en,
   input  wire  [sqrot_pkg::CSR_W-1:0]     csr_wr_data
);

   sqrot_pkg::ctl_cmd_type    cmd;
   sqrot_pkg::ctl_status_type status;

   // controller
   sqrot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req_word.command),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath
   sqrot_dp #(
      .MAX_SIZE    (MAX_SIZE),
      .PIXEL_WIDTH (PIXEL_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_word    (req_word),
      .cmd         (cmd),
      .status      (status),
      .rsp_word    (rsp_word)
   );

endmodule

`default_nettype wire
